// ----- rtl/rrts_pkg.sv -----
// Shared types and constants for the round-robin task scheduler.
// Used by rrts_table, rrts_ctrl, round_robin_task_scheduler and rrts_checker.
package rrts_pkg;

	localparam int TASK_SLOTS_DEF = 8;
	localparam int DELAY_W        = 32;
	localparam int TICK_W         = 32;
	localparam int S_TDATA_W      = 32;
	localparam int S_TUSER_W      = 2;
	localparam int M_TDATA_W      = 48;

	typedef enum logic [1:0] {
		KIND_CREATE = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_DELAY  = 2'd2,
		KIND_SCHED  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_READY   = 2'd0,
		ST_BLOCKED = 2'd1,
		ST_RUNNING = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_CREATE,
		OP_TICK,
		OP_WRITE,
		OP_SET_STATUS
	} tbl_op_t;

	typedef struct packed {
		tbl_op_t op;
		status_t st;
	} tbl_cmd_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CREATE,
		S_TICK,
		S_DELAY,
		S_RELEASE,
		S_SEARCH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [TICK_W-1:0] tick_count;
		logic [3:0]        task_total;
		logic              accepted;
		logic              idle;
		logic [2:0]        running_task;
	} res_t;

endpackage

// ----- rtl/round_robin_task_scheduler.sv -----
// Round-robin task scheduler top level: stream ports, sequencer, task table
// and the result register. Depends on rrts_pkg, rrts_ctrl and rrts_table.
//
// Input channel (s_*): one transaction per command. s_tuser carries the
// command kind (create, tick, delay current task, schedule), s_tdata the
// delay amount. s_tready is high only while no command is in progress.
// Output channel (m_*): exactly one result transaction per command, giving
// the scheduler state after the command.
// The next command is taken only after the previous result has entered the
// result register. Tick and schedule walk the task table one slot per cycle
// through a single table port, tick also through one decrement/zero-test unit.
// Reset (arst_n low) clears the table to all ready, the task count and tick
// counter to zero, and marks the scheduler idle.
// When the receiver stalls, the result is held in the output register; the
// next command is still accepted, and its result waits until the register
// frees.
module round_robin_task_scheduler #(
	parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rrts_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] delay_amount
	input  logic [rrts_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] kind
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [2:0] running_task, [3] idle, [4] accepted, [8:5] task_total,
	// [40:9] tick_count, [47:41] zero
	output logic [rrts_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(TASK_SLOTS);

	rrts_pkg::tbl_cmd_t           cmd;
	logic [IDX_W-1:0]             idx;
	logic [rrts_pkg::DELAY_W-1:0] wdata;
	rrts_pkg::status_t            rd_status;
	logic                         res_valid;
	logic                         res_ready;
	rrts_pkg::res_t               res;
	rrts_pkg::res_t               out_q;
	logic                         out_valid_q;

	rrts_ctrl #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_kind  (rrts_pkg::kind_t'(s_tuser)),
		.in_amount(s_tdata),
		.cmd      (cmd),
		.idx      (idx),
		.wdata    (wdata),
		.rd_status(rd_status),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	rrts_table #(
		.TASK_SLOTS(TASK_SLOTS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.idx      (idx),
		.wdata    (wdata),
		.rd_status(rd_status)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'b0000000, out_q};

endmodule

// ----- rtl/rrts_table.sv -----
// Task table: per-slot status and delay counter, with the shared
// decrement/zero-test unit used by the tick walk. Depends on rrts_pkg.
module rrts_table #(
	parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rrts_pkg::tbl_cmd_t           cmd,
	input  logic [$clog2(TASK_SLOTS)-1:0] idx,
	input  logic [rrts_pkg::DELAY_W-1:0] wdata,
	output rrts_pkg::status_t            rd_status
);

	rrts_pkg::status_t              status_q [TASK_SLOTS];
	logic [rrts_pkg::DELAY_W-1:0]   delay_q  [TASK_SLOTS];
	logic [rrts_pkg::DELAY_W-1:0]   dly_rd;
	logic [rrts_pkg::DELAY_W-1:0]   dly_dec;
	logic                           dly_nz;
	logic                           tick_hit;

	assign rd_status = status_q[idx];
	assign dly_rd    = delay_q[idx];
	assign dly_dec   = dly_rd - rrts_pkg::DELAY_W'(1);
	assign dly_nz    = (dly_rd != '0);
	assign tick_hit  = (cmd.op == rrts_pkg::OP_TICK) && (rd_status == rrts_pkg::ST_BLOCKED)
		&& dly_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TASK_SLOTS; i++) begin
				status_q[i] <= rrts_pkg::ST_READY;
			end
		end else begin
			case (cmd.op)
				rrts_pkg::OP_CREATE: begin
					status_q[idx] <= rrts_pkg::ST_READY;
				end
				rrts_pkg::OP_TICK: begin
					if (tick_hit && (dly_dec == '0)) begin
						status_q[idx] <= rrts_pkg::ST_READY;
					end
				end
				rrts_pkg::OP_WRITE, rrts_pkg::OP_SET_STATUS: begin
					status_q[idx] <= cmd.st;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			rrts_pkg::OP_CREATE: begin
				delay_q[idx] <= '0;
			end
			rrts_pkg::OP_TICK: begin
				if (tick_hit) begin
					delay_q[idx] <= dly_dec;
				end
			end
			rrts_pkg::OP_WRITE: begin
				delay_q[idx] <= wdata;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/rrts_ctrl.sv -----
// Sequencer for the scheduler: decodes each transaction, walks the task
// table one slot per cycle and holds the scalar state. Depends on rrts_pkg.
module rrts_ctrl #(
	parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rrts_pkg::kind_t               in_kind,
	input  logic [rrts_pkg::DELAY_W-1:0]  in_amount,
	output rrts_pkg::tbl_cmd_t            cmd,
	output logic [$clog2(TASK_SLOTS)-1:0] idx,
	output logic [rrts_pkg::DELAY_W-1:0]  wdata,
	input  rrts_pkg::status_t             rd_status,
	output logic                          res_valid,
	input  logic                          res_ready,
	output rrts_pkg::res_t                res
);

	localparam int IDX_W = $clog2(TASK_SLOTS);
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);

	rrts_pkg::state_t               state_q, state_n;
	rrts_pkg::kind_t                kind_q, kind_n;
	logic [rrts_pkg::DELAY_W-1:0]   amount_q, amount_n;
	logic [CNT_W-1:0]               num_q, num_n;
	logic [IDX_W-1:0]               cur_q, cur_n;
	logic                           idle_q, idle_n;
	logic [rrts_pkg::TICK_W-1:0]    ticks_q, ticks_n;
	logic [CNT_W-1:0]               ptr_q, ptr_n;
	logic [IDX_W-1:0]               pos_q, pos_n;
	logic [IDX_W-1:0]               cnt_q, cnt_n;
	logic                           acc_q, acc_n;

	logic                           cur_valid;
	logic [CNT_W-1:0]               cur_inc;
	logic [CNT_W-1:0]               pos_inc;
	logic [CNT_W-1:0]               cnt_inc;
	logic [IDX_W-1:0]               start_pos;
	logic [IDX_W-1:0]               pos_wrap;
	logic [IDX_W+2:0]               cur_wide;
	logic [CNT_W+3:0]               num_wide;

	assign cur_valid = !idle_q && (CNT_W'(cur_q) < num_q);
	assign cur_inc   = CNT_W'(cur_q) + CNT_W'(1);
	assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
	assign cnt_inc   = CNT_W'(cnt_q) + CNT_W'(1);
	assign start_pos = (!cur_valid || (cur_inc == num_q)) ? '0 : cur_inc[IDX_W-1:0];
	assign pos_wrap  = (pos_inc == num_q) ? '0 : pos_inc[IDX_W-1:0];
	assign cur_wide  = {3'b000, cur_q};
	assign num_wide  = {4'b0000, num_q};

	assign res.running_task = idle_q ? 3'b000 : cur_wide[2:0];
	assign res.idle         = idle_q;
	assign res.accepted     = acc_q;
	assign res.task_total   = num_wide[3:0];
	assign res.tick_count   = ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrts_pkg::S_IDLE;
			num_q   <= '0;
			cur_q   <= '0;
			idle_q  <= 1'b1;
			ticks_q <= '0;
			ptr_q   <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			acc_q   <= 1'b1;
			kind_q  <= rrts_pkg::KIND_CREATE;
		end else begin
			state_q <= state_n;
			num_q   <= num_n;
			cur_q   <= cur_n;
			idle_q  <= idle_n;
			ticks_q <= ticks_n;
			ptr_q   <= ptr_n;
			pos_q   <= pos_n;
			cnt_q   <= cnt_n;
			acc_q   <= acc_n;
			kind_q  <= kind_n;
		end
	end

	always_ff @(posedge clk) begin
		amount_q <= amount_n;
	end

	always_comb begin
		state_n   = state_q;
		kind_n    = kind_q;
		amount_n  = amount_q;
		num_n     = num_q;
		cur_n     = cur_q;
		idle_n    = idle_q;
		ticks_n   = ticks_q;
		ptr_n     = ptr_q;
		pos_n     = pos_q;
		cnt_n     = cnt_q;
		acc_n     = acc_q;
		cmd.op    = rrts_pkg::OP_NONE;
		cmd.st    = rrts_pkg::ST_READY;
		idx       = '0;
		wdata     = amount_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;

		case (state_q)
			rrts_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					kind_n   = in_kind;
					amount_n = in_amount;
					acc_n    = 1'b1;
					case (in_kind)
						rrts_pkg::KIND_CREATE: state_n = rrts_pkg::S_CREATE;
						rrts_pkg::KIND_TICK: begin
							ticks_n = ticks_q + rrts_pkg::TICK_W'(1);
							ptr_n   = '0;
							state_n = rrts_pkg::S_TICK;
						end
						rrts_pkg::KIND_DELAY: state_n = rrts_pkg::S_DELAY;
						default: state_n = rrts_pkg::S_RELEASE;
					endcase
				end
			end
			rrts_pkg::S_CREATE: begin
				idx = num_q[IDX_W-1:0];
				if (num_q == CNT_W'(TASK_SLOTS)) begin
					acc_n = 1'b0;
				end else begin
					cmd.op = rrts_pkg::OP_CREATE;
					num_n  = num_q + CNT_W'(1);
				end
				state_n = rrts_pkg::S_OUT;
			end
			rrts_pkg::S_TICK: begin
				idx = ptr_q[IDX_W-1:0];
				if (ptr_q == num_q) begin
					state_n = rrts_pkg::S_OUT;
				end else begin
					cmd.op = rrts_pkg::OP_TICK;
					ptr_n  = ptr_q + CNT_W'(1);
				end
			end
			rrts_pkg::S_DELAY: begin
				idx = cur_q;
				if (!cur_valid) begin
					acc_n = 1'b0;
				end else begin
					cmd.op = rrts_pkg::OP_WRITE;
					cmd.st = (amount_q == '0) ? rrts_pkg::ST_READY : rrts_pkg::ST_BLOCKED;
				end
				state_n = rrts_pkg::S_OUT;
			end
			rrts_pkg::S_RELEASE: begin
				idx = cur_q;
				if (cur_valid && (rd_status == rrts_pkg::ST_RUNNING)) begin
					cmd.op = rrts_pkg::OP_SET_STATUS;
					cmd.st = rrts_pkg::ST_READY;
				end
				if (num_q == '0) begin
					idle_n  = 1'b1;
					state_n = rrts_pkg::S_OUT;
				end else begin
					pos_n   = start_pos;
					cnt_n   = '0;
					state_n = rrts_pkg::S_SEARCH;
				end
			end
			rrts_pkg::S_SEARCH: begin
				idx = pos_q;
				if (rd_status == rrts_pkg::ST_READY) begin
					cmd.op  = rrts_pkg::OP_SET_STATUS;
					cmd.st  = rrts_pkg::ST_RUNNING;
					cur_n   = pos_q;
					idle_n  = 1'b0;
					state_n = rrts_pkg::S_OUT;
				end else begin
					pos_n = pos_wrap;
					cnt_n = cnt_inc[IDX_W-1:0];
					if (cnt_inc == num_q) begin
						idle_n  = 1'b1;
						state_n = rrts_pkg::S_OUT;
					end
				end
			end
			rrts_pkg::S_OUT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_n = rrts_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = rrts_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/rrts_checker.sv -----
// Port-level checks for round_robin_task_scheduler, bound to the top level.
// Depends on rrts_pkg.
module rrts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rrts_pkg::M_TDATA_W-1:0] m_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one command at a time: input closes right after a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready during command");

	// idle result reports task zero
	a_idle_task: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[3] |-> (m_tdata[2:0] == 3'b000))
		else $error("idle result with nonzero task");

	// padding bits stay zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[47:41] == 7'b0000000))
		else $error("nonzero padding in result");

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
